### sv/gpbm_pkg.sv
`timescale 1ns / 1ps
package gpbm_pkg;

  localparam int MAX_CONTIGS = 1024;
  localparam int ADDR_W      = $clog2(MAX_CONTIGS);
  localparam int CNT_W       = $clog2(MAX_CONTIGS + 1);

  localparam int BUCKET_W   = 16;
  localparam int SIZE_W     = 40;
  localparam int LARGE_W    = 16;
  localparam int LEN_W      = 32;
  localparam int IDX_W      = 11;
  localparam int POS_W      = 31;
  localparam int TOTAL_W    = 40;
  localparam int ACC_W      = TOTAL_W + 1;
  localparam int HALF_W     = SIZE_W / 2;
  localparam int PART_W     = LARGE_W + HALF_W;
  localparam int LIMIT_W    = LARGE_W + SIZE_W;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [BUCKET_W-1:0] BUCKET_MAX   = '1;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = '1;
  localparam logic [IDX_W-1:0]    UNMAPPED_IDX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUCKET_COUNT    = 3'd0,
    REG_BUCKET_SIZE     = 3'd1,
    REG_FULL_BUCKETS    = 3'd2,
    REG_DROP_DUPLICATES = 3'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket_count;
    logic [SIZE_W-1:0]   bucket_size;
    logic [LARGE_W-1:0]  full_buckets;
    logic                drop_duplicates;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic             special;
    logic             bad;
    logic             keep;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    F_IDLE,
    F_LOOK
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL0,
    B_MUL1,
    B_SEL,
    B_CMP,
    B_DIV,
    B_FIN,
    B_DONE
  } back_state_t;

endpackage

### sv/gpbm_if.sv
`timescale 1ns / 1ps
interface gpbm_in_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [gpbm_pkg::LEN_W-1:0]     contig_length;
  logic signed [gpbm_pkg::IDX_W-1:0] contig_index;
  logic [gpbm_pkg::POS_W-1:0]     position;
  logic                           is_duplicate;

  modport source (output valid, op, contig_length, contig_index, position, is_duplicate,
                  input ready);
  modport sink (input valid, op, contig_length, contig_index, position, is_duplicate,
                output ready);
endinterface

interface gpbm_out_if;
  logic                          valid;
  logic                          ready;
  logic [gpbm_pkg::BUCKET_W-1:0] bucket;
  logic                          keep;
  logic                          bad_contig;

  modport source (output valid, bucket, keep, bad_contig, input ready);
  modport sink (input valid, bucket, keep, bad_contig, output ready);
endinterface

### sv/gpbm_ram.sv
`timescale 1ns / 1ps
module gpbm_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/gpbm_front.sv
`timescale 1ns / 1ps
module gpbm_front (
  input  logic                clk,
  input  logic                rst,
  gpbm_in_if.sink             in_ch,
  input  gpbm_pkg::cfg_t      cfg,
  input  gpbm_pkg::q_stat_t   q_stat,
  output logic                push,
  output gpbm_pkg::q_entry_t  push_data
);

  gpbm_pkg::front_state_t st, st_next;

  logic [gpbm_pkg::CNT_W-1:0]   contig_count;
  logic [gpbm_pkg::TOTAL_W-1:0] running_total;
  logic [gpbm_pkg::POS_W-1:0]   pos_r;
  logic                         keep_r;
  logic                         unmapped_r;
  logic                         bad_r;

  logic [gpbm_pkg::IDX_W-1:0]   idx_u;
  logic                         is_read;
  logic                         load_go;
  logic                         read_go;
  logic                         ram_we;
  logic                         unmapped;
  logic                         bad;
  logic [gpbm_pkg::ACC_W-1:0]   sum;
  logic [gpbm_pkg::TOTAL_W-1:0] ram_rdata;

  assign idx_u   = in_ch.contig_index;
  assign is_read = gpbm_pkg::op_t'(in_ch.op) == gpbm_pkg::OP_READ;
  assign load_go = in_ch.valid && in_ch.ready && !is_read;
  assign read_go = in_ch.valid && in_ch.ready && is_read;
  assign ram_we  = load_go && (contig_count < gpbm_pkg::CNT_W'(gpbm_pkg::MAX_CONTIGS));

  assign unmapped = idx_u == gpbm_pkg::UNMAPPED_IDX;
  assign bad      = !unmapped &&
                    (idx_u[gpbm_pkg::IDX_W-1] || (32'(idx_u) >= 32'(contig_count)));
  assign sum      = {1'b0, running_total} +
                    gpbm_pkg::ACC_W'(in_ch.contig_length);

  gpbm_ram #(
    .WIDTH(gpbm_pkg::TOTAL_W),
    .DEPTH(gpbm_pkg::MAX_CONTIGS)
  ) u_prefix (
    .clk  (clk),
    .we   (ram_we),
    .waddr(contig_count[gpbm_pkg::ADDR_W-1:0]),
    .wdata(running_total),
    .re   (read_go),
    .raddr(idx_u[gpbm_pkg::ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    st_next = st;
    unique case (st)
      gpbm_pkg::F_IDLE: begin
        if (in_ch.valid && is_read) begin
          st_next = gpbm_pkg::F_LOOK;
        end
      end
      gpbm_pkg::F_LOOK: begin
        if (!q_stat.full) begin
          st_next = gpbm_pkg::F_IDLE;
        end
      end
      default: st_next = gpbm_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    push        = 1'b0;
    unique case (st)
      gpbm_pkg::F_IDLE: in_ch.ready = 1'b1;
      gpbm_pkg::F_LOOK: push = !q_stat.full;
      default: begin
        in_ch.ready = 1'b0;
        push        = 1'b0;
      end
    endcase
  end

  assign push_data.acc     = {1'b0, ram_rdata} + gpbm_pkg::ACC_W'(pos_r);
  assign push_data.special = unmapped_r || bad_r;
  assign push_data.bad     = bad_r;
  assign push_data.keep    = keep_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= gpbm_pkg::F_IDLE;
      contig_count  <= '0;
      running_total <= '0;
    end else begin
      st <= st_next;
      if (ram_we) begin
        contig_count  <= contig_count + 1'b1;
        running_total <= sum[gpbm_pkg::ACC_W-1] ? gpbm_pkg::TOTAL_MAX
                                                 : sum[gpbm_pkg::TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (read_go) begin
      pos_r      <= in_ch.position;
      keep_r     <= !(cfg.drop_duplicates && in_ch.is_duplicate);
      unmapped_r <= unmapped;
      bad_r      <= bad;
    end
  end

endmodule

### sv/gpbm_queue.sv
`timescale 1ns / 1ps
module gpbm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gpbm_pkg::q_entry_t push_data,
  input  logic               pop,
  output gpbm_pkg::q_entry_t head,
  output gpbm_pkg::q_stat_t  q_stat
);

  gpbm_pkg::q_entry_t            slots [gpbm_pkg::Q_DEPTH];
  logic [gpbm_pkg::Q_PTR_W-1:0]  wptr;
  logic [gpbm_pkg::Q_PTR_W-1:0]  rptr;
  logic [gpbm_pkg::Q_CNT_W-1:0]  fill;

  assign q_stat.full  = fill == gpbm_pkg::Q_CNT_W'(gpbm_pkg::Q_DEPTH);
  assign q_stat.empty = fill == '0;
  assign head         = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == gpbm_pkg::Q_PTR_W'(gpbm_pkg::Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == gpbm_pkg::Q_PTR_W'(gpbm_pkg::Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

### sv/gpbm_back.sv
`timescale 1ns / 1ps
module gpbm_back (
  input  logic               clk,
  input  logic               rst,
  input  gpbm_pkg::cfg_t     cfg,
  input  gpbm_pkg::q_entry_t head,
  input  gpbm_pkg::q_stat_t  q_stat,
  output logic               pop,
  gpbm_out_if.source         out_ch
);

  localparam int DIV_CNT_W = $clog2(gpbm_pkg::ACC_W);

  gpbm_pkg::back_state_t st, st_next;

  logic [gpbm_pkg::ACC_W-1:0]    acc;
  logic                          bad_r;
  logic                          keep_r;
  logic [gpbm_pkg::SIZE_W-1:0]   size;
  logic [gpbm_pkg::PART_W-1:0]   p_lo;
  logic [gpbm_pkg::PART_W-1:0]   p_hi;
  logic [gpbm_pkg::LIMIT_W-1:0]  limit;
  logic [gpbm_pkg::SIZE_W-1:0]   rem;
  logic [gpbm_pkg::ACC_W-1:0]    quo;
  logic [gpbm_pkg::SIZE_W-1:0]   dvs;
  logic                          add_lb;
  logic [DIV_CNT_W-1:0]          cnt;
  logic [gpbm_pkg::BUCKET_W-1:0] res;

  logic                          out_valid;
  logic [gpbm_pkg::BUCKET_W-1:0] out_bucket;
  logic                          out_keep;
  logic                          out_bad;

  logic                          load_out;
  logic                          beyond;
  logic                          size_one;
  logic [gpbm_pkg::ACC_W-1:0]    trial;
  logic                          ge;
  logic [gpbm_pkg::ACC_W:0]      fin_sum;

  assign beyond   = gpbm_pkg::LIMIT_W'(acc) > limit;
  assign size_one = size == gpbm_pkg::SIZE_W'(1);
  assign trial    = {rem, quo[gpbm_pkg::ACC_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign fin_sum  = add_lb ? ((gpbm_pkg::ACC_W + 1)'(cfg.full_buckets) + {1'b0, quo})
                           : {1'b0, quo};

  always_comb begin
    st_next = st;
    unique case (st)
      gpbm_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          st_next = head.special ? gpbm_pkg::B_DONE : gpbm_pkg::B_MUL0;
        end
      end
      gpbm_pkg::B_MUL0: st_next = gpbm_pkg::B_MUL1;
      gpbm_pkg::B_MUL1: st_next = gpbm_pkg::B_SEL;
      gpbm_pkg::B_SEL:  st_next = gpbm_pkg::B_CMP;
      gpbm_pkg::B_CMP:  st_next = (beyond && size_one) ? gpbm_pkg::B_DONE : gpbm_pkg::B_DIV;
      gpbm_pkg::B_DIV: begin
        if (cnt == '0) begin
          st_next = gpbm_pkg::B_FIN;
        end
      end
      gpbm_pkg::B_FIN: st_next = gpbm_pkg::B_DONE;
      gpbm_pkg::B_DONE: begin
        if (!out_valid || out_ch.ready) begin
          st_next = gpbm_pkg::B_IDLE;
        end
      end
      default: st_next = gpbm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (st)
      gpbm_pkg::B_IDLE: pop = !q_stat.empty;
      gpbm_pkg::B_DONE: load_out = !out_valid || out_ch.ready;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= gpbm_pkg::B_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      gpbm_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          acc    <= head.acc;
          bad_r  <= head.bad;
          keep_r <= head.keep;
          size   <= (cfg.bucket_size == '0) ? gpbm_pkg::SIZE_W'(1) : cfg.bucket_size;
          res    <= cfg.bucket_count;
        end
      end
      gpbm_pkg::B_MUL0: begin
        p_lo <= gpbm_pkg::PART_W'(cfg.full_buckets) *
                gpbm_pkg::PART_W'(size[gpbm_pkg::HALF_W-1:0]);
      end
      gpbm_pkg::B_MUL1: begin
        p_hi <= gpbm_pkg::PART_W'(cfg.full_buckets) *
                gpbm_pkg::PART_W'(size[gpbm_pkg::SIZE_W-1:gpbm_pkg::HALF_W]);
      end
      gpbm_pkg::B_SEL: begin
        limit <= gpbm_pkg::LIMIT_W'(p_lo) + {p_hi, {gpbm_pkg::HALF_W{1'b0}}};
      end
      gpbm_pkg::B_CMP: begin
        rem <= '0;
        cnt <= DIV_CNT_W'(gpbm_pkg::ACC_W - 1);
        res <= cfg.full_buckets;
        if (beyond) begin
          quo    <= acc - limit[gpbm_pkg::ACC_W-1:0];
          dvs    <= size - 1'b1;
          add_lb <= 1'b1;
        end else begin
          quo    <= acc;
          dvs    <= size;
          add_lb <= 1'b0;
        end
      end
      gpbm_pkg::B_DIV: begin
        rem <= ge ? gpbm_pkg::SIZE_W'(trial - {1'b0, dvs}) : trial[gpbm_pkg::SIZE_W-1:0];
        quo <= {quo[gpbm_pkg::ACC_W-2:0], ge};
        cnt <= cnt - 1'b1;
      end
      gpbm_pkg::B_FIN: begin
        res <= (fin_sum > (gpbm_pkg::ACC_W + 1)'(gpbm_pkg::BUCKET_MAX))
               ? gpbm_pkg::BUCKET_MAX : fin_sum[gpbm_pkg::BUCKET_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bucket <= res;
      out_keep   <= keep_r;
      out_bad    <= bad_r;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.bucket     = out_bucket;
  assign out_ch.keep       = out_keep;
  assign out_ch.bad_contig = out_bad;

endmodule

### sv/genome_position_bucket_mapper.sv
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// in_ch     in   valid/ready    op, contig_length, contig_index, position, is_duplicate
// out_ch    out  valid/ready    bucket, keep, bad_contig
// cfg       in   cfg_we only    cfg_index, cfg_data
//
// a load is taken in F_IDLE; a read waits in F_LOOK (table lookup) for queue room;
// the back forms the limit product (B_MUL0, B_MUL1, B_SEL), compares (B_CMP), runs
// 41 divider steps (B_DIV), then B_FIN and B_DONE; unmapped or bad reads skip to B_DONE
// a 2-entry queue between front and back; output register holds while out_ch stalls
// synchronous reset clears count and total, presets config; prefix table is not cleared
module genome_position_bucket_mapper (
  input  logic                                clk,
  input  logic                                rst,
  gpbm_in_if.sink                             in_ch,
  gpbm_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [gpbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  gpbm_pkg::cfg_t     cfg;
  gpbm_pkg::q_entry_t push_data;
  gpbm_pkg::q_entry_t head;
  gpbm_pkg::q_stat_t  q_stat;
  logic               push;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bucket_count    <= gpbm_pkg::BUCKET_W'(1);
      cfg.bucket_size     <= gpbm_pkg::SIZE_W'(1);
      cfg.full_buckets    <= gpbm_pkg::LARGE_W'(1);
      cfg.drop_duplicates <= 1'b0;
    end else if (cfg_we) begin
      unique case (gpbm_pkg::cfg_reg_t'(cfg_index))
        gpbm_pkg::REG_BUCKET_COUNT:    cfg.bucket_count <= cfg_data[gpbm_pkg::BUCKET_W-1:0];
        gpbm_pkg::REG_BUCKET_SIZE:     cfg.bucket_size <= cfg_data[gpbm_pkg::SIZE_W-1:0];
        gpbm_pkg::REG_FULL_BUCKETS:    cfg.full_buckets <= cfg_data[gpbm_pkg::LARGE_W-1:0];
        gpbm_pkg::REG_DROP_DUPLICATES: cfg.drop_duplicates <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  gpbm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  gpbm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  gpbm_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .q_stat(q_stat),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

### sv/gpbm_checker.sv
`timescale 1ns / 1ps
module gpbm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [gpbm_pkg::BUCKET_W-1:0]       out_bucket,
  input logic                                out_keep,
  input logic                                out_bad,
  input logic                                cfg_we,
  input logic [gpbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [gpbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [gpbm_pkg::BUCKET_W-1:0] bc_shadow;
  logic                          drop_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      bc_shadow   <= gpbm_pkg::BUCKET_W'(1);
      drop_shadow <= 1'b0;
    end else if (cfg_we) begin
      if (gpbm_pkg::cfg_reg_t'(cfg_index) == gpbm_pkg::REG_BUCKET_COUNT) begin
        bc_shadow <= cfg_data[gpbm_pkg::BUCKET_W-1:0];
      end
      if (gpbm_pkg::cfg_reg_t'(cfg_index) == gpbm_pkg::REG_DROP_DUPLICATES) begin
        drop_shadow <= cfg_data[0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_bucket) && $stable(out_keep) && $stable(out_bad))
    else $error("result changed while stalled");

  a_bad_bucket: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bad |-> out_bucket == bc_shadow)
    else $error("bad contig not sent to extra bucket");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_keep |-> drop_shadow)
    else $error("read dropped with duplicate dropping off");

endmodule

bind genome_position_bucket_mapper gpbm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_bucket(out_ch.bucket),
  .out_keep  (out_ch.keep),
  .out_bad   (out_ch.bad_contig),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
